// ===== rtl/vssm_pkg.sv =====
// ----------------------------------------------------------------------------
// vssm_pkg
// Shared types, constants and helpers of the vehicle speed source manager.
// ----------------------------------------------------------------------------
`default_nettype none

package vssm_pkg;

    // speed source codes
    localparam logic SRC_BUS  = 1'b0;
    localparam logic SRC_WIRE = 1'b1;

    localparam logic [15:0] FINE_MAX = 16'd64000;
    localparam logic [7:0]  KMH_MAX  = 8'd255;

    // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 2^22
    localparam int          DIV25_SHIFT = 26;
    localparam logic [21:0] DIV25_MUL   = 22'd2684355;

    // configuration port
    localparam int         APB_ADDR_W   = 3;
    localparam int         APB_DATA_W   = 32;
    localparam logic [0:0] REG_ENG_CAL  = 1'b0;

    typedef struct packed {
        logic        speed_source;
        logic [7:0]  speed_kmh;
        logic [15:0] vehicle_speed_fine;
        logic [15:0] engine_speed_out;
        logic        moving;
        logic [7:0]  accel_out;
    } speed_res_t;

    typedef struct packed {
        logic load;
        logic is_bus;
        logic inhibit;
        logic odo_seen;
    } dist_ctrl_t;

    function automatic logic [16:0] div_by_25(input logic [20:0] x);
        logic [42:0] prod;
        prod = {22'd0, x} * {21'd0, DIV25_MUL};
        return prod[DIV25_SHIFT +: 17];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vssm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// vssm_apb_regs
// APB register file holding the engine-side speed calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vssm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vssm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vssm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [15:0]                      eng_cal
);
    import vssm_pkg::*;

    logic [15:0] eng_cal_reg;
    logic [15:0] eng_cal_next;
    logic        wr_en;
    logic        sel_cal;

    assign pready  = 1'b1;
    assign sel_cal = (paddr[APB_ADDR_W-1:2] == REG_ENG_CAL);
    assign wr_en   = psel && penable && pwrite && sel_cal;

    always_comb
    begin
        eng_cal_next = eng_cal_reg;
        if (wr_en)
        begin
            eng_cal_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_cal_reg <= '0;
        end
        else
        begin
            eng_cal_reg <= eng_cal_next;
        end
    end

    assign prdata  = sel_cal ? {{(APB_DATA_W-16){1'b0}}, eng_cal_reg} : '0;
    assign eng_cal = eng_cal_reg;

endmodule

`default_nettype wire

// ===== rtl/vssm_speed_conv.sv =====
// ----------------------------------------------------------------------------
// vssm_speed_conv
// Source selection and speed/acceleration conversion for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_speed_conv (
    input  wire logic                  abs_present,
    input  wire logic                  stability_ctrl_present,
    input  wire logic [15:0]           bus_speed,
    input  wire logic [7:0]            bus_accel,
    input  wire logic [15:0]           wire_speed_raw,
    input  wire logic [7:0]            wire_accel,
    input  wire logic [15:0]           eng_cal,
    output vssm_pkg::speed_res_t       res
);
    import vssm_pkg::*;

    logic [16:0] bus_fine_raw;   // bus_speed * 128 / 100, unsaturated
    logic [9:0]  bus_kmh_raw;
    logic [15:0] bus_fine;
    logic [7:0]  bus_kmh;
    logic [15:0] bus_eng;
    logic        src;

    assign src = (abs_present || stability_ctrl_present) ? SRC_BUS : SRC_WIRE;

    // *128/100 == *32/25; floor(fine/128) is then exactly bus_speed/100
    assign bus_fine_raw = div_by_25({bus_speed, 5'd0});
    assign bus_kmh_raw  = bus_fine_raw[16:7];

    assign bus_fine = (bus_fine_raw > {1'b0, FINE_MAX}) ? FINE_MAX : bus_fine_raw[15:0];
    assign bus_kmh  = (bus_kmh_raw > {2'b00, KMH_MAX}) ? KMH_MAX : bus_kmh_raw[7:0];
    assign bus_eng  = (eng_cal > FINE_MAX) ? FINE_MAX : eng_cal;

    always_comb
    begin
        res.speed_source = src;
        if (src == SRC_BUS)
        begin
            res.speed_kmh          = bus_kmh;
            res.vehicle_speed_fine = bus_fine;
            res.engine_speed_out   = bus_eng;
            res.moving             = (bus_speed != 16'd0);
            res.accel_out          = bus_accel;
        end
        else
        begin
            res.speed_kmh          = wire_speed_raw[15:8];
            res.vehicle_speed_fine = {1'b0, wire_speed_raw[15:1]};
            res.engine_speed_out   = {1'b0, wire_speed_raw[15:1]};
            res.moving             = (wire_speed_raw != 16'd0);
            res.accel_out          = wire_accel;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vssm_distance.sv =====
// ----------------------------------------------------------------------------
// vssm_distance
// Distance state: stored bus distance, inhibit history and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_distance (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vssm_pkg::dist_ctrl_t  ctrl,
    input  wire logic [15:0]           bus_distance,
    input  wire logic [15:0]           computed_distance,
    input  wire logic [15:0]           wire_distance,
    output logic      [15:0]           held_dist,
    output logic      [15:0]           prev_dist
);
    import vssm_pkg::*;

    logic [15:0] stored_dist_reg;
    logic [15:0] stored_dist_next;
    logic        inhibit_last_reg;
    logic        inhibit_last_next;
    logic [15:0] held_dist_reg;
    logic [15:0] held_dist_next;
    logic [15:0] prev_hold_reg;
    logic [15:0] prev_hold_next;
    logic [15:0] new_dist;

    assign new_dist = (!ctrl.inhibit && ctrl.odo_seen) ? bus_distance : computed_distance;

    always_comb
    begin
        stored_dist_next  = stored_dist_reg;
        inhibit_last_next = inhibit_last_reg;
        held_dist_next    = held_dist_reg;
        prev_hold_next    = prev_hold_reg;
        if (ctrl.load)
        begin
            if (ctrl.is_bus)
            begin
                prev_hold_next    = stored_dist_reg;
                stored_dist_next  = new_dist;
                inhibit_last_next = ctrl.inhibit;
                // frozen for the tick on which the inhibit flag toggles
                if (ctrl.inhibit == inhibit_last_reg)
                begin
                    held_dist_next = new_dist;
                end
            end
            else
            begin
                held_dist_next = wire_distance;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_dist_reg  <= '0;
            inhibit_last_reg <= 1'b0;
            held_dist_reg    <= '0;
            prev_hold_reg    <= '0;
        end
        else
        begin
            stored_dist_reg  <= stored_dist_next;
            inhibit_last_reg <= inhibit_last_next;
            held_dist_reg    <= held_dist_next;
            prev_hold_reg    <= prev_hold_next;
        end
    end

    // values after this tick's update, captured by the result register
    assign held_dist = held_dist_next;
    assign prev_dist = prev_hold_next;

endmodule

`default_nettype wire

// ===== rtl/vehicle_speed_source_manager_top.sv =====
// ----------------------------------------------------------------------------
// vehicle_speed_source_manager_top
// Flow: a tick accepted into the input register moves into the result register
// once that stage is free or being emptied, and its result is then valid.
// Throughput: one tick per cycle while out_ready is high; the input register and
// the result register each advance whenever the stage after them is free or being emptied.
// Reset: rst_n clears both stage valids, the distance state and the
// calibration register; the block takes input right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_speed_source_manager_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vssm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vssm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vssm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             abs_present,
    input  wire logic                             stability_ctrl_present,
    input  wire logic [15:0]                      bus_speed,
    input  wire logic [7:0]                       bus_accel,
    input  wire logic [15:0]                      wire_speed_raw,
    input  wire logic [7:0]                       wire_accel,
    input  wire logic                             distance_inhibit,
    input  wire logic                             odo_frame_a_seen,
    input  wire logic                             odo_frame_b_seen,
    input  wire logic [15:0]                      bus_distance,
    input  wire logic [15:0]                      computed_distance,
    input  wire logic [15:0]                      wire_distance,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  speed_source,
    output logic      [7:0]                       speed_kmh,
    output logic      [15:0]                      vehicle_speed_fine,
    output logic      [15:0]                      engine_speed_out,
    output logic                                  moving,
    output logic      [7:0]                       accel_out,
    output logic      [15:0]                      distance_out,
    output logic      [15:0]                      distance_previous
);
    import vssm_pkg::*;

    logic [15:0] eng_cal;

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        abs_reg;
    logic        stab_reg;
    logic [15:0] bus_speed_reg;
    logic [7:0]  bus_accel_reg;
    logic [15:0] wire_speed_reg;
    logic [7:0]  wire_accel_reg;
    logic        inhibit_reg;
    logic        odo_a_reg;
    logic        odo_b_reg;
    logic [15:0] bus_dist_reg;
    logic [15:0] comp_dist_reg;
    logic [15:0] wire_dist_reg;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    speed_res_t  res_reg;
    logic [15:0] dist_out_reg;
    logic [15:0] dist_prev_reg;

    logic        in_xfer;
    logic        s1_adv;
    speed_res_t  res;
    dist_ctrl_t  dctrl;
    logic [15:0] held_dist;
    logic [15:0] prev_dist;

    vssm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eng_cal (eng_cal)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            abs_reg        <= abs_present;
            stab_reg       <= stability_ctrl_present;
            bus_speed_reg  <= bus_speed;
            bus_accel_reg  <= bus_accel;
            wire_speed_reg <= wire_speed_raw;
            wire_accel_reg <= wire_accel;
            inhibit_reg    <= distance_inhibit;
            odo_a_reg      <= odo_frame_a_seen;
            odo_b_reg      <= odo_frame_b_seen;
            bus_dist_reg   <= bus_distance;
            comp_dist_reg  <= computed_distance;
            wire_dist_reg  <= wire_distance;
        end
    end

    vssm_speed_conv u_conv (
        .abs_present            (abs_reg),
        .stability_ctrl_present (stab_reg),
        .bus_speed              (bus_speed_reg),
        .bus_accel              (bus_accel_reg),
        .wire_speed_raw         (wire_speed_reg),
        .wire_accel             (wire_accel_reg),
        .eng_cal                (eng_cal),
        .res                    (res)
    );

    assign dctrl.load     = s1_adv;
    assign dctrl.is_bus   = (res.speed_source == SRC_BUS);
    assign dctrl.inhibit  = inhibit_reg;
    assign dctrl.odo_seen = odo_a_reg || odo_b_reg;

    vssm_distance u_dist (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (dctrl),
        .bus_distance      (bus_dist_reg),
        .computed_distance (comp_dist_reg),
        .wire_distance     (wire_dist_reg),
        .held_dist         (held_dist),
        .prev_dist         (prev_dist)
    );

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg       <= res;
            dist_out_reg  <= held_dist;
            dist_prev_reg <= prev_dist;
        end
    end

    assign out_valid          = out_valid_reg;
    assign speed_source       = res_reg.speed_source;
    assign speed_kmh          = res_reg.speed_kmh;
    assign vehicle_speed_fine = res_reg.vehicle_speed_fine;
    assign engine_speed_out   = res_reg.engine_speed_out;
    assign moving             = res_reg.moving;
    assign accel_out          = res_reg.accel_out;
    assign distance_out       = dist_out_reg;
    assign distance_previous  = dist_prev_reg;

    // an empty result stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result stage");

    // a tick leaving the input register always shows up as a result
    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

    a_fine_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (vehicle_speed_fine <= FINE_MAX) && (engine_speed_out <= FINE_MAX))
        else $error("fine or engine speed above saturation limit");

    a_wire_engine_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (speed_source == SRC_WIRE) |-> engine_speed_out == vehicle_speed_fine)
        else $error("wire engine speed differs from fine speed");

endmodule

`default_nettype wire

// ===== sim/vehicle_speed_source_manager_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vehicle_speed_source_manager_top_tb
// Drives speed ticks through the input channel with random gaps and output
// stalls. A local model of source selection, speed scaling and distance hold
// predicts each result, and a monitor compares every output transfer field by
// field. Calibration writes are made over the APB port between drained phases.
// ----------------------------------------------------------------------------

module vehicle_speed_source_manager_top_tb;

    import vssm_pkg::*;

    localparam int                  STALL_LIMIT  = 4000;
    localparam int                  IDLE_PCT     = 27;
    localparam int                  RANDOM_TICKS = 300;
    localparam logic [APB_ADDR_W-1:0] ENG_CAL_ADDR = APB_ADDR_W'(4 * REG_ENG_CAL);
    // one slot past the only register, decoded as nothing
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR   = APB_ADDR_W'(4);

    typedef struct packed {
        logic        abs_present;
        logic        stability_ctrl_present;
        logic [15:0] bus_speed;
        logic [7:0]  bus_accel;
        logic [15:0] wire_speed_raw;
        logic [7:0]  wire_accel;
        logic        distance_inhibit;
        logic        odo_frame_a_seen;
        logic        odo_frame_b_seen;
        logic [15:0] bus_distance;
        logic [15:0] computed_distance;
        logic [15:0] wire_distance;
    } speed_tick_t;

    typedef struct packed {
        logic        speed_source;
        logic [7:0]  speed_kmh;
        logic [15:0] vehicle_speed_fine;
        logic [15:0] engine_speed_out;
        logic        moving;
        logic [7:0]  accel_out;
        logic [15:0] distance_out;
        logic [15:0] distance_previous;
    } speed_report_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic        in_valid               = 1'b0;
    logic        in_ready;
    logic        abs_present            = 1'b0;
    logic        stability_ctrl_present = 1'b0;
    logic [15:0] bus_speed              = '0;
    logic [7:0]  bus_accel              = '0;
    logic [15:0] wire_speed_raw         = '0;
    logic [7:0]  wire_accel             = '0;
    logic        distance_inhibit       = 1'b0;
    logic        odo_frame_a_seen       = 1'b0;
    logic        odo_frame_b_seen       = 1'b0;
    logic [15:0] bus_distance           = '0;
    logic [15:0] computed_distance      = '0;
    logic [15:0] wire_distance          = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        speed_source;
    logic [7:0]  speed_kmh;
    logic [15:0] vehicle_speed_fine;
    logic [15:0] engine_speed_out;
    logic        moving;
    logic [7:0]  accel_out;
    logic [15:0] distance_out;
    logic [15:0] distance_previous;

    // model state
    logic [15:0] eng_cal      = '0;
    logic [15:0] stored_dist  = '0;
    logic        last_inhibit = 1'b0;
    logic [15:0] held_dist    = '0;
    logic [15:0] prev_dist    = '0;

    speed_tick_t   pending_ticks[$];
    speed_report_t expected_reports[$];
    speed_tick_t   next_tick;
    speed_report_t got_report;

    logic calm        = 1'b0;
    int   fail_count  = 0;
    int   stall_count = 0;

    // random sequence state
    logic on_bus    = 1'b1;
    logic inhibit_now = 1'b0;

    vehicle_speed_source_manager_top i_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .abs_present            (abs_present),
        .stability_ctrl_present (stability_ctrl_present),
        .bus_speed              (bus_speed),
        .bus_accel              (bus_accel),
        .wire_speed_raw         (wire_speed_raw),
        .wire_accel             (wire_accel),
        .distance_inhibit       (distance_inhibit),
        .odo_frame_a_seen       (odo_frame_a_seen),
        .odo_frame_b_seen       (odo_frame_b_seen),
        .bus_distance           (bus_distance),
        .computed_distance      (computed_distance),
        .wire_distance          (wire_distance),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .speed_source           (speed_source),
        .speed_kmh              (speed_kmh),
        .vehicle_speed_fine     (vehicle_speed_fine),
        .engine_speed_out       (engine_speed_out),
        .moving                 (moving),
        .accel_out              (accel_out),
        .distance_out           (distance_out),
        .distance_previous      (distance_previous)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // source is picked first, then speed is scaled with the new source
    function automatic speed_report_t convert_tick(input speed_tick_t t);
        speed_report_t r;
        logic [31:0]   scaled;
        logic [15:0]   dist_new;
        r = '0;
        if (t.abs_present || t.stability_ctrl_present)
        begin
            r.speed_source = SRC_BUS;
            scaled = 32'(t.bus_speed) / 32'd100;
            r.speed_kmh = (scaled > 32'(KMH_MAX)) ? KMH_MAX : scaled[7:0];
            scaled = (32'(t.bus_speed) * 32'd128) / 32'd100;
            r.vehicle_speed_fine = (scaled > 32'(FINE_MAX)) ? FINE_MAX : scaled[15:0];
            r.engine_speed_out = (eng_cal > FINE_MAX) ? FINE_MAX : eng_cal;
            r.moving = (t.bus_speed != 16'd0);
            r.accel_out = t.bus_accel;
            prev_dist = stored_dist;
            dist_new = (!t.distance_inhibit && (t.odo_frame_a_seen || t.odo_frame_b_seen))
                       ? t.bus_distance : t.computed_distance;
            stored_dist = dist_new;
            // output frozen on the tick where the inhibit flag toggles
            if (t.distance_inhibit == last_inhibit)
                held_dist = dist_new;
            last_inhibit = t.distance_inhibit;
        end
        else
        begin
            r.speed_source = SRC_WIRE;
            r.speed_kmh = t.wire_speed_raw[15:8];
            r.vehicle_speed_fine = {1'b0, t.wire_speed_raw[15:1]};
            r.engine_speed_out = {1'b0, t.wire_speed_raw[15:1]};
            r.moving = (t.wire_speed_raw != 16'd0);
            r.accel_out = t.wire_accel;
            held_dist = t.wire_distance;
        end
        r.distance_out = held_dist;
        r.distance_previous = prev_dist;
        return r;
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'(25450 + $urandom_range(100));
            3: return 16'(49998 + $urandom_range(4));
            4: return 16'($urandom_range(300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_tick(input logic a, input logic e, input logic [15:0] bspd,
                            input logic [15:0] wraw, input logic inh,
                            input logic oa, input logic ob);
        speed_tick_t t;
        t.abs_present            = a;
        t.stability_ctrl_present = e;
        t.bus_speed              = bspd;
        t.bus_accel              = 8'($urandom);
        t.wire_speed_raw         = wraw;
        t.wire_accel             = 8'($urandom);
        t.distance_inhibit       = inh;
        t.odo_frame_a_seen       = oa;
        t.odo_frame_b_seen       = ob;
        t.bus_distance           = 16'($urandom);
        t.computed_distance      = 16'($urandom);
        t.wire_distance          = 16'($urandom);
        pending_ticks.push_back(t);
    endtask

    // mostly steady source and inhibit runs, with occasional switches
    task automatic add_random_ticks(input int count);
        logic [1:0] presence;
        logic [1:0] odo;
        repeat (count)
        begin
            if ($urandom_range(99) < 8)
                on_bus = !on_bus;
            if ($urandom_range(99) < 10)
                inhibit_now = !inhibit_now;
            presence = on_bus ? 2'($urandom_range(1, 3)) : 2'b00;
            odo = ($urandom_range(99) < 25) ? 2'b00 : 2'($urandom_range(1, 3));
            add_tick(presence[0], presence[1], pick_speed(), pick_speed(),
                     inhibit_now, odo[0], odo[1]);
        end
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ENG_CAL_ADDR)
            eng_cal = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_tick = pending_ticks.pop_front();
                in_valid               <= 1'b1;
                abs_present            <= next_tick.abs_present;
                stability_ctrl_present <= next_tick.stability_ctrl_present;
                bus_speed              <= next_tick.bus_speed;
                bus_accel              <= next_tick.bus_accel;
                wire_speed_raw         <= next_tick.wire_speed_raw;
                wire_accel             <= next_tick.wire_accel;
                distance_inhibit       <= next_tick.distance_inhibit;
                odo_frame_a_seen       <= next_tick.odo_frame_a_seen;
                odo_frame_b_seen       <= next_tick.odo_frame_b_seen;
                bus_distance           <= next_tick.bus_distance;
                computed_distance      <= next_tick.computed_distance;
                wire_distance          <= next_tick.wire_distance;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: result check first, then predict the tick taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    got_report = expected_reports.pop_front();
                    check_field("speed_source", got_report.speed_source, speed_source);
                    check_field("speed_kmh", got_report.speed_kmh, speed_kmh);
                    check_field("vehicle_speed_fine", got_report.vehicle_speed_fine,
                                vehicle_speed_fine);
                    check_field("engine_speed_out", got_report.engine_speed_out,
                                engine_speed_out);
                    check_field("moving", got_report.moving, moving);
                    check_field("accel_out", got_report.accel_out, accel_out);
                    check_field("distance_out", got_report.distance_out, distance_out);
                    check_field("distance_previous", got_report.distance_previous,
                                distance_previous);
                end
            end
            if (in_valid && in_ready)
                expected_reports.push_back(convert_tick({abs_present,
                    stability_ctrl_present, bus_speed, bus_accel, wire_speed_raw,
                    wire_accel, distance_inhibit, odo_frame_a_seen, odo_frame_b_seen,
                    bus_distance, computed_distance, wire_distance}));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("vehicle_speed_source_manager_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] cal_settings[6];
        cal_settings = '{16'hFFFF, 16'd64000, 16'd64001, 16'd0,
                         16'($urandom), 16'($urandom_range(64000))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first tick after reset is bus, calibration still at reset value
        add_tick(1'b1, 1'b0, 16'd0,     16'($urandom), 1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1, 16'hFFFF,  16'($urandom), 1'b0, 1'b1, 1'b0);
        // inhibit toggles: held output freezes, computed distance used
        add_tick(1'b1, 1'b1, 16'd25499, 16'($urandom), 1'b1, 1'b1, 1'b1);
        add_tick(1'b1, 1'b0, 16'd25500, 16'($urandom), 1'b1, 1'b0, 1'b1);
        add_tick(1'b0, 1'b1, 16'd25599, 16'($urandom), 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 16'd50000, 16'($urandom), 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 16'd50001, 16'($urandom), 1'b0, 1'b0, 1'b1);
        add_tick(1'b0, 1'b1, 16'd99,    16'($urandom), 1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 16'd100,   16'($urandom), 1'b0, 1'b1, 1'b0);
        // wire ticks leave bus distance state alone
        add_tick(1'b0, 1'b0, 16'($urandom), 16'd0,     1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b0, 16'($urandom), 16'd1,     1'b0, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 16'($urandom), 16'd255,   1'b1, 1'b0, 1'b1);
        add_tick(1'b0, 1'b0, 16'($urandom), 16'd256,   1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 16'($urandom), 16'hFFFF,  1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b0, 16'd1,     16'($urandom), 1'b1, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1, 16'd12345, 16'($urandom), 1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b0, 16'd64000, 16'($urandom), 1'b0, 1'b1, 1'b0);
        wait_drained();

        // write outside the register map must not touch the calibration
        apb_write(SPARE_ADDR, $urandom);
        add_tick(1'b1, 1'b0, 16'd3000,  16'($urandom), 1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 16'($urandom), 16'd7777,  1'b0, 1'b0, 1'b0);
        add_tick(1'b0, 1'b1, 16'd40000, 16'($urandom), 1'b0, 1'b0, 1'b1);
        wait_drained();

        for (int i = 0; i < 6; i++)
        begin
            apb_write(ENG_CAL_ADDR, {16'($urandom), cal_settings[i]});
            calm = (i == 2);
            add_random_ticks(RANDOM_TICKS);
            wait_drained();
        end
        calm = 1'b0;

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("vehicle_speed_source_manager_top_tb passed");
        else
            $display("vehicle_speed_source_manager_top_tb failed");
        $finish;
    end

endmodule
